// ===== hdl/pwdd_pkg.sv =====
// pwdd_pkg: shared types, symbol windows and the period classifier
// for the pulse-width dual-channel deframer
// no dependencies
package pwdd_pkg;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;
    localparam int QUEUE_DEPTH = 4;

    localparam int FRAME_W = 14;
    localparam logic [3:0] FRAME_BITS = 4'd14;

    localparam int MARGIN_PCT = 15;

    localparam int PER_N_HDR  = 3250;
    localparam int PER_S_HDR  = 2750;
    localparam int PER_N_ZERO = 750;
    localparam int PER_S_ZERO = 1250;
    localparam int PER_N_ONE  = 1750;
    localparam int PER_S_ONE  = 2250;

    localparam int MRG_N_HDR  = PER_N_HDR * MARGIN_PCT / 100;
    localparam int MRG_S_HDR  = PER_S_HDR * MARGIN_PCT / 100;
    localparam int MRG_N_ZERO = PER_N_ZERO * MARGIN_PCT / 100;
    localparam int MRG_S_ZERO = PER_S_ZERO * MARGIN_PCT / 100;
    localparam int MRG_N_ONE  = PER_N_ONE * MARGIN_PCT / 100;
    localparam int MRG_S_ONE  = PER_S_ONE * MARGIN_PCT / 100;

    localparam logic [15:0] N_HDR_LO  = 16'(PER_N_HDR - MRG_N_HDR);
    localparam logic [15:0] N_HDR_HI  = 16'(PER_N_HDR + MRG_N_HDR);
    localparam logic [15:0] S_HDR_LO  = 16'(PER_S_HDR - MRG_S_HDR);
    localparam logic [15:0] S_HDR_HI  = 16'(PER_S_HDR + MRG_S_HDR);
    localparam logic [15:0] N_ZERO_LO = 16'(PER_N_ZERO - MRG_N_ZERO);
    localparam logic [15:0] N_ZERO_HI = 16'(PER_N_ZERO + MRG_N_ZERO);
    localparam logic [15:0] S_ZERO_LO = 16'(PER_S_ZERO - MRG_S_ZERO);
    localparam logic [15:0] S_ZERO_HI = 16'(PER_S_ZERO + MRG_S_ZERO);
    localparam logic [15:0] N_ONE_LO  = 16'(PER_N_ONE - MRG_N_ONE);
    localparam logic [15:0] N_ONE_HI  = 16'(PER_N_ONE + MRG_N_ONE);
    localparam logic [15:0] S_ONE_LO  = 16'(PER_S_ONE - MRG_S_ONE);
    localparam logic [15:0] S_ONE_HI  = 16'(PER_S_ONE + MRG_S_ONE);

    localparam logic [15:0] REST_MIN = 16'd350;
    localparam logic [15:0] REST_MAX = 16'd5000;

    typedef enum logic [2:0] {
        SYM_N_HDR  = 3'd0,
        SYM_S_HDR  = 3'd1,
        SYM_N_ZERO = 3'd2,
        SYM_S_ZERO = 3'd3,
        SYM_N_ONE  = 3'd4,
        SYM_S_ONE  = 3'd5,
        SYM_BAD    = 3'd7
    } sym_t;

    typedef struct packed {
        sym_t sym;
        logic rest_ok;
    } sym_item_t;

    typedef struct packed {
        logic [5:0] pad;
        logic [3:0] progress;
        logic [6:0] frame_parameter;
        logic [3:0] target_id;
        logic [2:0] frame_type;
    } result_t;

    function automatic logic in_window(input logic [15:0] period,
                                       input logic [15:0] lo,
                                       input logic [15:0] hi);
        return (period >= lo) && (period <= hi);
    endfunction

    // first match wins: E, e, 0, o, 1, i
    function automatic sym_t classify(input logic [15:0] period);
        sym_t sym;
        if (in_window(period, N_HDR_LO, N_HDR_HI)) begin
            sym = SYM_N_HDR;
        end else if (in_window(period, S_HDR_LO, S_HDR_HI)) begin
            sym = SYM_S_HDR;
        end else if (in_window(period, N_ZERO_LO, N_ZERO_HI)) begin
            sym = SYM_N_ZERO;
        end else if (in_window(period, S_ZERO_LO, S_ZERO_HI)) begin
            sym = SYM_S_ZERO;
        end else if (in_window(period, N_ONE_LO, N_ONE_HI)) begin
            sym = SYM_N_ONE;
        end else if (in_window(period, S_ONE_LO, S_ONE_HI)) begin
            sym = SYM_S_ONE;
        end else begin
            sym = SYM_BAD;
        end
        return sym;
    endfunction

endpackage

// ===== hdl/pwdd_front.sv =====
// pwdd_front: input side, classifies each measured beat into a symbol
// and a rest-range flag for the queue
// depends on pwdd_pkg
module pwdd_front
    import pwdd_pkg::*;
(
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,   // pulse_period, rest_duration
    output logic                 item_valid,
    input  logic                 item_ready,
    output sym_item_t            item
);

    logic [15:0] pulse_period;
    logic [15:0] rest_duration;

    assign pulse_period  = s_axis_tdata[15:0];
    assign rest_duration = s_axis_tdata[31:16];

    always_comb begin
        item.sym     = classify(pulse_period);
        item.rest_ok = (rest_duration >= REST_MIN) && (rest_duration <= REST_MAX);
    end

    assign item_valid    = s_axis_tvalid;
    assign s_axis_tready = item_ready;

endmodule

// ===== hdl/pwdd_queue.sv =====
// pwdd_queue: short register queue of classified symbols between
// front and back
// depends on pwdd_pkg
module pwdd_queue
    import pwdd_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    output logic      push_ready,
    input  sym_item_t push_item,
    output logic      pop_valid,
    input  logic      pop_ready,
    output sym_item_t pop_item
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    sym_item_t         entry_reg [Depth];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;
    logic              push, pop;

    assign push_ready = (count_reg != CntW'(Depth));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/pwdd_back.sv =====
// pwdd_back: north and south channel shift state, frame assembly and
// the output register
// depends on pwdd_pkg
module pwdd_back
    import pwdd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  sym_item_t             item,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tuser
);

    logic               north_collecting_reg, north_collecting_next;
    logic [3:0]         north_count_reg, north_count_next;
    logic [FRAME_W-1:0] north_bits_reg, north_bits_next;
    logic               south_collecting_reg, south_collecting_next;
    logic [3:0]         south_count_reg, south_count_next;
    logic [FRAME_W-1:0] south_bits_reg, south_bits_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic               m_tuser_reg, m_tuser_next;
    result_t            result_reg, result_next;

    logic               pop;
    logic               is_hdr;
    logic               north_done, south_done;
    logic [FRAME_W-1:0] frame;

    assign item_ready = !m_tvalid_reg || m_axis_tready;
    assign pop        = item_valid && item_ready;
    assign is_hdr     = (item.sym == SYM_N_HDR) || (item.sym == SYM_S_HDR);

    always_comb begin
        north_collecting_next = north_collecting_reg;
        north_count_next      = north_count_reg;
        north_bits_next       = north_bits_reg;
        south_collecting_next = south_collecting_reg;
        south_count_next      = south_count_reg;
        south_bits_next       = south_bits_reg;
        north_done            = 1'b0;
        south_done            = 1'b0;
        frame                 = '0;

        if (pop) begin
            if ((!is_hdr && !item.rest_ok) || item.sym == SYM_BAD) begin
                north_collecting_next = 1'b0;
                south_collecting_next = 1'b0;
            end else begin
                unique case (item.sym) inside
                    SYM_N_HDR: begin
                        north_collecting_next = 1'b1;
                        north_count_next      = '0;
                        north_bits_next       = '0;
                    end
                    SYM_S_HDR: begin
                        south_collecting_next = 1'b1;
                        south_count_next      = '0;
                        south_bits_next       = '0;
                    end
                    SYM_N_ZERO, SYM_N_ONE: begin
                        if (north_collecting_reg) begin
                            north_bits_next  = {north_bits_reg[FRAME_W-2:0],
                                                item.sym == SYM_N_ONE};
                            north_count_next = north_count_reg + 1'b1;
                            if (north_count_next == FRAME_BITS) begin
                                north_done            = 1'b1;
                                frame                 = north_bits_next;
                                north_collecting_next = 1'b0;
                            end
                        end
                    end
                    SYM_S_ZERO, SYM_S_ONE: begin
                        if (south_collecting_reg) begin
                            south_bits_next  = {south_bits_reg[FRAME_W-2:0],
                                                item.sym == SYM_S_ONE};
                            south_count_next = south_count_reg + 1'b1;
                            if (south_count_next == FRAME_BITS) begin
                                south_done            = 1'b1;
                                frame                 = south_bits_next;
                                south_collecting_next = 1'b0;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_axis_tready;
        m_tuser_next  = m_tuser_reg;
        result_next   = result_reg;
        if (pop) begin
            m_tvalid_next               = 1'b1;
            m_tuser_next                = north_done || south_done;
            result_next.pad             = '0;
            result_next.frame_type      = frame[13:11];
            result_next.target_id       = frame[10:7];
            result_next.frame_parameter = frame[6:0];
            if (north_collecting_next) begin
                result_next.progress = north_count_next + 1'b1;
            end else if (south_collecting_next) begin
                result_next.progress = south_count_next + 1'b1;
            end else begin
                result_next.progress = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            north_collecting_reg <= 1'b0;
            north_count_reg      <= '0;
            north_bits_reg       <= '0;
            south_collecting_reg <= 1'b0;
            south_count_reg      <= '0;
            south_bits_reg       <= '0;
            m_tvalid_reg         <= 1'b0;
        end else begin
            north_collecting_reg <= north_collecting_next;
            north_count_reg      <= north_count_next;
            north_bits_reg       <= north_bits_next;
            south_collecting_reg <= south_collecting_next;
            south_count_reg      <= south_count_next;
            south_bits_reg       <= south_bits_next;
            m_tvalid_reg         <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tuser_reg <= m_tuser_next;
        result_reg  <= result_next;
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tuser  = m_tuser_reg;
    assign m_axis_tdata  = result_reg;

`ifndef NO_ASSERTIONS
    a_north_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        north_collecting_reg |-> (north_count_reg < FRAME_BITS))
        else $error("north count out of range while collecting");

    a_south_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        south_collecting_reg |-> (south_count_reg < FRAME_BITS))
        else $error("south count out of range while collecting");

    a_north_done: assert property (@(posedge aclk) disable iff (!aresetn)
        north_done |=> (m_tvalid_reg && m_tuser_reg && !north_collecting_reg))
        else $error("north frame completion not reported");

    a_south_done: assert property (@(posedge aclk) disable iff (!aresetn)
        south_done |=> (m_tvalid_reg && m_tuser_reg && !south_collecting_reg))
        else $error("south frame completion not reported");

    a_no_frame_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tuser_reg) |-> (result_reg.frame_type == '0 &&
            result_reg.target_id == '0 && result_reg.frame_parameter == '0))
        else $error("frame fields set without a completed frame");
`endif

endmodule

// ===== hdl/pulse_width_dual_channel_deframer.sv =====
// pulse_width_dual_channel_deframer: top level, front classifier, symbol
// queue and channel back end
// depends on pwdd_pkg, pwdd_front, pwdd_queue, pwdd_back
//
// channel   dir  tdata                                            tuser
// s_axis    in   [15:0] pulse_period, [31:16] rest_duration       -
// m_axis    out  [2:0] type, [6:3] id, [13:7] param, [17:14] prog [0] frame_valid
//
// one beat in and one beat out per cycle while the output is not stalled and the
// queue is not full; a beat accepted at the input is written to a queue entry,
// then popped by the back end into the output register
// reset clears channel state, queue pointers and the output valid
// the queue holds QueueDepth symbols; s_axis_tready drops when it is full
// output stalls hold the back end while the front keeps filling the queue
module pulse_width_dual_channel_deframer
    import pwdd_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // pulse_period, rest_duration
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // type, id, param, progress
    output logic                  m_axis_tuser    // frame_valid
);

    sym_item_t front_item;
    logic      front_valid, front_ready;
    sym_item_t back_item;
    logic      back_valid, back_ready;

    pwdd_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .item_valid    (front_valid),
        .item_ready    (front_ready),
        .item          (front_item)
    );

    pwdd_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_item   (back_item)
    );

    pwdd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (back_valid),
        .item_ready    (back_ready),
        .item          (back_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== tb/sv/tb_pulse_width_dual_channel_deframer.sv =====
// tb_pulse_width_dual_channel_deframer: self-checking bench for the deframer,
// directed window edges then random north and south frames under random backpressure
// depends on pwdd_pkg and pulse_width_dual_channel_deframer
`timescale 1ns / 100ps

module tb_pulse_width_dual_channel_deframer
    import pwdd_pkg::*;
();

    localparam int unsigned WIN_PCT = 15;
    localparam int unsigned REST_FLOOR = 350;
    localparam int unsigned REST_CEIL = 5000;
    localparam int unsigned FRAME_LEN = 14;
    localparam int ITEM_GOAL = 1000;
    localparam int CALM_FROM = 850;
    localparam int LONG_HOLD = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam bit [15:0] WINDOW_EDGES [18] = '{
        16'd637, 16'd638, 16'd862, 16'd863, 16'd1062, 16'd1063,
        16'd1437, 16'd1438, 16'd1487, 16'd1488, 16'd2012, 16'd2013,
        16'd2337, 16'd2338, 16'd2762, 16'd2763, 16'd3737, 16'd3738
    };

    typedef struct packed {
        logic       frame_valid;
        logic [2:0] frame_type;
        logic [3:0] target_id;
        logic [6:0] frame_parameter;
        logic [3:0] progress;
    } frame_result_t;

    class deframe_scoreboard;
        bit            north_on, south_on;
        bit [3:0]      north_cnt, south_cnt;
        bit [13:0]     north_word, south_word;
        frame_result_t expected_q[$];
        int            errors;
        int            beats;

        function new();
            north_on = 0;
            south_on = 0;
            north_cnt = 0;
            south_cnt = 0;
            north_word = 0;
            south_word = 0;
            errors = 0;
            beats = 0;
        endfunction

        function int unsigned nominal_of(sym_t s);
            case (s)
                SYM_N_HDR:  return 3250;
                SYM_S_HDR:  return 2750;
                SYM_N_ZERO: return 750;
                SYM_S_ZERO: return 1250;
                SYM_N_ONE:  return 1750;
                SYM_S_ONE:  return 2250;
                default:    return 0;
            endcase
        endfunction

        // windows are tested in priority order, first hit wins
        function sym_t symbol_of(bit [15:0] p);
            sym_t        order [6];
            int unsigned nom, mrg;
            order = '{SYM_N_HDR, SYM_S_HDR, SYM_N_ZERO, SYM_S_ZERO, SYM_N_ONE, SYM_S_ONE};
            foreach (order[k]) begin
                nom = nominal_of(order[k]);
                mrg = nom * WIN_PCT / 100;
                if (p >= nom - mrg && p <= nom + mrg) begin
                    return order[k];
                end
            end
            return SYM_BAD;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_pulse(bit [15:0] period, bit [15:0] rest);
            sym_t          s;
            frame_result_t r;
            bit [13:0]     word;
            s = symbol_of(period);
            r = '0;
            word = '0;
            if (s != SYM_N_HDR && s != SYM_S_HDR && (rest < REST_FLOOR || rest > REST_CEIL)) begin
                north_on = 0;
                south_on = 0;
            end else if (s == SYM_BAD) begin
                north_on = 0;
                south_on = 0;
            end else if (s == SYM_N_HDR) begin
                north_on = 1;
                north_cnt = 0;
                north_word = 0;
            end else if (s == SYM_S_HDR) begin
                south_on = 1;
                south_cnt = 0;
                south_word = 0;
            end else if (s == SYM_N_ZERO || s == SYM_N_ONE) begin
                if (north_on) begin
                    north_word = {north_word[12:0], s == SYM_N_ONE};
                    north_cnt = north_cnt + 1;
                    if (north_cnt == FRAME_LEN) begin
                        r.frame_valid = 1;
                        word = north_word;
                        north_on = 0;
                    end
                end
            end else begin
                if (south_on) begin
                    south_word = {south_word[12:0], s == SYM_S_ONE};
                    south_cnt = south_cnt + 1;
                    if (south_cnt == FRAME_LEN) begin
                        r.frame_valid = 1;
                        word = south_word;
                        south_on = 0;
                    end
                end
            end
            if (r.frame_valid) begin
                r.frame_type = word[13:11];
                r.target_id = word[10:7];
                r.frame_parameter = word[6:0];
            end
            if (north_on) begin
                r.progress = north_cnt + 4'd1;
            end else if (south_on) begin
                r.progress = south_cnt + 4'd1;
            end
            expected_q.push_back(r);
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                if (errors <= 10) begin
                    $display("beat %0d %s mismatch: expected %0d, got %0d",
                             beats, field, want, got);
                end
            end
        endfunction

        function void check_result(bit [OUT_DATA_W-1:0] data, bit flag);
            frame_result_t want;
            beats++;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("beat %0d unexpected: tdata %h tuser %0d", beats, data, flag);
                end
                return;
            end
            want = expected_q.pop_front();
            compare("frame_valid", want.frame_valid, flag);
            compare("frame_type", want.frame_type, data[2:0]);
            compare("target_id", want.target_id, data[6:3]);
            compare("frame_parameter", want.frame_parameter, data[13:7]);
            compare("progress", want.progress, data[17:14]);
            compare("pad", 0, data[23:18]);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    deframe_scoreboard sb;
    int                sent;
    int                stall_cycles;
    bit                calm;
    bit                long_hold;

    pulse_width_dual_channel_deframer i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic bit [15:0] pick_period(sym_t s);
        bit [15:0]   p;
        int unsigned nom, mrg;
        if (s == SYM_BAD) begin
            do p = 16'($urandom); while (sb.symbol_of(p) != SYM_BAD);
        end else begin
            nom = sb.nominal_of(s);
            mrg = nom * WIN_PCT / 100;
            do p = 16'($urandom_range(nom - mrg, nom + mrg)); while (sb.symbol_of(p) != s);
        end
        return p;
    endfunction

    function automatic bit [15:0] pick_rest(bit good);
        if (good) begin
            return 16'($urandom_range(REST_FLOOR, REST_CEIL));
        end else if ($urandom_range(0, 1) == 0) begin
            return 16'($urandom_range(0, REST_FLOOR - 1));
        end
        return 16'($urandom_range(REST_CEIL + 1, 65535));
    endfunction

    task automatic send_pulse(input bit [15:0] period, input bit [15:0] rest);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rest, period};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sent++;
        if (!calm && $urandom_range(0, 11) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic send_symbol(input sym_t s, input bit rest_good);
        send_pulse(pick_period(s), pick_rest(rest_good));
    endtask

    // header then 14 data beats, with occasional other-channel traffic and breaks
    task automatic send_frame(input bit south);
        sym_t hdr, zero, one, other_zero, other_one;
        int   r;
        hdr        = south ? SYM_S_HDR  : SYM_N_HDR;
        zero       = south ? SYM_S_ZERO : SYM_N_ZERO;
        one        = south ? SYM_S_ONE  : SYM_N_ONE;
        other_zero = south ? SYM_N_ZERO : SYM_S_ZERO;
        other_one  = south ? SYM_N_ONE  : SYM_S_ONE;
        send_pulse(pick_period(hdr), 16'($urandom));
        for (int k = 0; k < FRAME_LEN; k++) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                send_symbol($urandom_range(0, 1) ? other_one : other_zero, 1'b1);
            end else if (r == 4) begin
                send_symbol(SYM_BAD, 1'($urandom_range(0, 1)));
            end else if (r == 5) begin
                send_symbol(zero, 1'b0);
            end
            send_symbol($urandom_range(0, 1) ? one : zero, 1'b1);
        end
    endtask

    task automatic send_frame_pair();
        send_pulse(pick_period(SYM_N_HDR), 16'($urandom));
        send_pulse(pick_period(SYM_S_HDR), 16'($urandom));
        for (int k = 0; k < FRAME_LEN; k++) begin
            send_symbol($urandom_range(0, 1) ? SYM_N_ONE : SYM_N_ZERO, 1'b1);
            send_symbol($urandom_range(0, 1) ? SYM_S_ONE : SYM_S_ZERO, 1'b1);
        end
    endtask

    task automatic wait_empty();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata, m_axis_tuser);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_pulse(s_axis_tdata[15:0], s_axis_tdata[31:16]);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        m_axis_tready <= 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (long_hold) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold = 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        int r;
        bit held, drained;
        held = 0;
        drained = 0;
        sb = new();
        sent = 0;
        calm = 0;
        long_hold = 0;
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: ignored data, extremes, header rest, rest bounds, window edges
        send_pulse(16'd750, 16'd2000);
        send_pulse(16'd0, 16'd0);
        send_pulse(16'hffff, 16'hffff);
        send_pulse(16'd3250, 16'd0);
        send_pulse(16'd750, 16'd350);
        send_pulse(16'd1750, 16'd5000);
        send_pulse(16'd2750, 16'hffff);
        send_pulse(16'd1250, 16'd349);
        send_pulse(16'd3250, 16'd1000);
        send_pulse(16'd1750, 16'd5001);
        foreach (WINDOW_EDGES[k]) begin
            send_pulse(WINDOW_EDGES[k], 16'd2000);
        end

        while (sent < ITEM_GOAL) begin
            if (sent >= CALM_FROM) begin
                calm = 1;
            end
            if (!held && sent >= 300) begin
                long_hold = 1;
                held = 1;
            end
            if (!drained && sent >= 600) begin
                wait_empty();
                drained = 1;
            end
            r = $urandom_range(0, 9);
            if (r < 7) begin
                send_frame(1'($urandom_range(0, 1)));
            end else if (r == 7) begin
                send_frame_pair();
            end else if (r == 8) begin
                send_pulse(16'($urandom), 16'($urandom));
            end else begin
                send_symbol(sym_t'($urandom_range(SYM_N_ZERO, SYM_S_ONE)),
                            1'($urandom_range(0, 1)));
            end
        end

        wait_empty();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
